[rtl/oct_pkg.sv]
// Shared types, constants and helper functions for the open count table.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package oct_pkg;

   // Table geometry and counter width.
   localparam int NODES      = 16;
   localparam int CPUS       = 16;
   localparam int COUNT_BITS = 16;

   // Fixed field widths of the channels.
   localparam int FUNC_BITS    = 3;
   localparam int NODE_BITS    = 8;
   localparam int CPU_BITS     = 4;
   localparam int VERDICT_BITS = 2;

   // Derived widths.
   localparam int IDX_BITS        = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int ITER_BITS       = IDX_BITS + 1;
   localparam int TALLY_DEPTH     = NODES * CPUS;
   localparam int TALLY_ADDR_BITS = (TALLY_DEPTH > 1) ? $clog2(TALLY_DEPTH) : 1;

   typedef logic [FUNC_BITS-1:0]       func_type;
   typedef logic [NODE_BITS-1:0]       node_id_type;
   typedef logic [CPU_BITS-1:0]        cpu_num_type;
   typedef logic [COUNT_BITS-1:0]      count_type;
   typedef logic [IDX_BITS-1:0]        idx_type;
   typedef logic [ITER_BITS-1:0]       iter_type;
   typedef logic [TALLY_ADDR_BITS-1:0] tally_addr_type;

   // Event codes; codes above FUNC_NODE_DOWN are other events.
   localparam func_type FUNC_OPEN       = 3'd0;
   localparam func_type FUNC_CLOSE      = 3'd1;
   localparam func_type FUNC_LCPU_DOWN  = 3'd2;
   localparam func_type FUNC_RCPU_DOWN  = 3'd3;
   localparam func_type FUNC_NODE_DOWN  = 3'd4;

   typedef enum logic [VERDICT_BITS-1:0] {
      VERDICT_GO   = 2'd0,
      VERDICT_STOP = 2'd1,
      VERDICT_FULL = 2'd2
   } verdict_type;

   localparam idx_type   LAST_IDX  = idx_type'(NODES - 1);
   localparam iter_type  ITER_END  = iter_type'(NODES);
   localparam iter_type  ITER_ONE  = iter_type'(1);
   localparam count_type COUNT_ONE = count_type'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_TALLY_RD,
      ST_MODIFY,
      ST_ALLOC,
      ST_SUM,
      ST_RESPOND
   } seq_state_type;

   // One entry of the node table memory.
   typedef struct packed {
      node_id_type node;
      count_type   total;
   } node_entry_type;

   typedef struct packed {
      idx_type     raddr;
      logic        we;
      idx_type     waddr;
      node_id_type wnode;
      count_type   wtotal;
   } node_cmd_type;

   typedef struct packed {
      tally_addr_type raddr;
      logic           we;
      tally_addr_type waddr;
      count_type      wdata;
      logic           row_clr;
      idx_type        clr_row;
   } tally_cmd_type;

   typedef struct packed {
      logic             busy;
      logic [NODES-1:0] slot_used;
   } seq_status_type;

   // A count is positive when it is nonzero and its sign bit is clear.
   function automatic logic cnt_positive(count_type v);
      cnt_positive = (v != '0) && !v[COUNT_BITS-1];
   endfunction

   function automatic logic cpu_in_range(cpu_num_type c);
      cpu_in_range = (int'(c) < CPUS);
   endfunction

   function automatic logic is_cpu_down(func_type f);
      is_cpu_down = (f == FUNC_LCPU_DOWN) || (f == FUNC_RCPU_DOWN);
   endfunction

   // Flat address of one CPU counter of one table entry.
   function automatic tally_addr_type tally_addr(idx_type e, int c);
      tally_addr = tally_addr_type'(int'(e) * CPUS + c);
   endfunction

endpackage

`default_nettype wire

[rtl/oct_req_if.sv]
// Event channel: valid/ready handshake with the event fields as payload.
// Depends on oct_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface oct_req_if import oct_pkg::*; ();
   logic        valid;
   logic        ready;
   func_type    func;
   node_id_type node_num;
   cpu_num_type cpu_num;
   logic        from_ancestor;
   logic        is_link_monitor;

   modport source (output valid, func, node_num, cpu_num, from_ancestor,
                   is_link_monitor, input ready);
   modport sink   (input valid, func, node_num, cpu_num, from_ancestor,
                   is_link_monitor, output ready);
endinterface

`default_nettype wire

[rtl/oct_rsp_if.sv]
// Verdict channel: valid/ready handshake carrying one verdict per event.
// Depends on oct_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface oct_rsp_if import oct_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [VERDICT_BITS-1:0] verdict;

   modport source (output valid, verdict, input ready);
   modport sink   (input valid, verdict, output ready);
endinterface

`default_nettype wire

[rtl/oct_csr_if.sv]
// Register write channel: valid/ready handshake carrying the local node number.
// Depends on oct_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface oct_csr_if import oct_pkg::*; ();
   logic        valid;
   logic        ready;
   node_id_type local_node;

   modport source (output valid, local_node, input ready);
   modport sink   (input valid, local_node, output ready);
endinterface

`default_nettype wire

[rtl/oct_node_mem.sv]
// Node table memory: node number and node counter per entry, one read port
// with a registered read, one write port. Depends on oct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oct_node_mem import oct_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire node_cmd_type   cmd,
   output node_entry_type      rd_entry
);

   node_entry_type   node_ram [NODES];
   node_entry_type   rd_data_ff;
   logic             rd_vld_ff;
   logic [NODES-1:0] vld_ff;
   logic [NODES-1:0] vld_in;

   // An entry reads as zero until its first write.
   always_comb begin
      vld_in = vld_ff;
      if (cmd.we) begin
         vld_in[cmd.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         node_ram[cmd.waddr] <= '{node: cmd.wnode, total: cmd.wtotal};
      end
      rd_data_ff <= node_ram[cmd.raddr];
      rd_vld_ff  <= vld_ff[cmd.raddr];
   end

   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[rtl/oct_tally_mem.sv]
// CPU counter memory: one counter per entry and CPU, registered read, one
// write port, and a clear of a whole entry row. Depends on oct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oct_tally_mem import oct_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tally_cmd_type cmd,
   output count_type          rd_data
);

   count_type              tally_ram [TALLY_DEPTH];
   count_type              rd_data_ff;
   logic                   rd_vld_ff;
   logic [TALLY_DEPTH-1:0] vld_ff;
   logic [TALLY_DEPTH-1:0] vld_in;

   // Valid bits: a row clear drops the whole row, a write marks its word.
   always_comb begin
      vld_in = vld_ff;
      if (cmd.row_clr) begin
         for (int c = 0; c < CPUS; c++) begin
            vld_in[tally_addr(cmd.clr_row, c)] = 1'b0;
         end
      end else if (cmd.we) begin
         vld_in[cmd.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         tally_ram[cmd.waddr] <= cmd.wdata;
      end
      rd_data_ff <= tally_ram[cmd.raddr];
      rd_vld_ff  <= vld_ff[cmd.raddr];
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[rtl/oct_seq.sv]
// Event sequencer: walks the node table to search, updates the counters by
// read-modify-write, then walks the table again to sum and free entries.
// Depends on oct_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module oct_seq import oct_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire node_id_type    local_node,
   oct_req_if.sink             req,
   oct_rsp_if.source           rsp,
   output node_cmd_type        node_cmd,
   input  wire node_entry_type rd_entry,
   output tally_cmd_type       tally_cmd,
   input  wire count_type      tally_rd,
   output seq_status_type      status
);

   seq_state_type    state_ff, state_in;
   func_type         func_ff, func_in;
   node_id_type      node_ff, node_in;
   cpu_num_type      cpu_ff, cpu_in;
   logic             cpu_ok_ff, cpu_ok_in;
   iter_type         iss_ff, iss_in;
   logic             cmp_vld_ff, cmp_vld_in;
   idx_type          cmp_idx_ff, cmp_idx_in;
   idx_type          hit_idx_ff, hit_idx_in;
   logic             free_found_ff, free_found_in;
   idx_type          free_idx_ff, free_idx_in;
   count_type        total_ff, total_in;
   count_type        sum_ff, sum_in;
   logic [NODES-1:0] slot_used_ff, slot_used_in;
   verdict_type      verdict_ff, verdict_in;
   logic             rsp_valid_ff, rsp_valid_in;
   verdict_type      rsp_verdict_ff, rsp_verdict_in;

   logic        req_fire;
   logic        bypass;
   logic        last_cmp;
   logic        match;
   logic        free_avail;
   logic        down_skip;
   logic        rsp_free;
   logic        issuing;
   logic        entry_pos;
   node_id_type entry_node;
   count_type   new_total;
   count_type   new_tally;
   count_type   sum_next;

   // Decode of the current beat, compare stage and modify stage.
   always_comb begin
      req_fire   = req.valid && req.ready;
      bypass     = (req.func > FUNC_NODE_DOWN) ||
                   ((req.func <= FUNC_CLOSE) && req.from_ancestor && !req.is_link_monitor);
      last_cmp   = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
      entry_node = (cmp_idx_ff == '0) ? local_node : rd_entry.node;
      match      = cmp_vld_ff && slot_used_ff[cmp_idx_ff] && (entry_node == node_ff);
      free_avail = free_found_ff || !slot_used_ff[cmp_idx_ff];
      down_skip  = is_cpu_down(func_ff) && (!cpu_ok_ff || (tally_rd == '0));
      rsp_free   = !rsp_valid_ff || rsp.ready;
      issuing    = ((state_ff == ST_SEARCH) || (state_ff == ST_SUM)) && (iss_ff < ITER_END);
      entry_pos  = cnt_positive(rd_entry.total);
      sum_next   = entry_pos ? (sum_ff + rd_entry.total) : sum_ff;
      unique case (func_ff)
         FUNC_OPEN: begin
            new_total = total_ff + COUNT_ONE;
            new_tally = tally_rd + COUNT_ONE;
         end
         FUNC_CLOSE: begin
            new_total = total_ff - COUNT_ONE;
            new_tally = tally_rd - COUNT_ONE;
         end
         FUNC_LCPU_DOWN, FUNC_RCPU_DOWN: begin
            new_total = total_ff - tally_rd;
            new_tally = '0;
         end
         default: begin
            new_total = '0;
            new_tally = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = bypass ? ST_RESPOND : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (match) begin
               state_in = ST_TALLY_RD;
            end else if (last_cmp) begin
               state_in = ((func_ff == FUNC_OPEN) && free_avail) ? ST_ALLOC : ST_RESPOND;
            end
         end
         ST_TALLY_RD: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            state_in = down_skip ? ST_RESPOND : ST_SUM;
         end
         ST_ALLOC: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (last_cmp) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Handshake outputs and memory commands.
   always_comb begin
      req.ready   = (state_ff == ST_IDLE);
      rsp.valid   = rsp_valid_ff;
      rsp.verdict = rsp_verdict_ff;

      node_cmd.raddr  = iss_ff[IDX_BITS-1:0];
      node_cmd.we     = 1'b0;
      node_cmd.waddr  = hit_idx_ff;
      node_cmd.wnode  = node_ff;
      node_cmd.wtotal = new_total;

      tally_cmd.raddr   = tally_addr(hit_idx_ff, int'(cpu_ff));
      tally_cmd.we      = 1'b0;
      tally_cmd.waddr   = tally_addr(hit_idx_ff, int'(cpu_ff));
      tally_cmd.wdata   = new_tally;
      tally_cmd.row_clr = 1'b0;
      tally_cmd.clr_row = hit_idx_ff;

      unique case (state_ff)
         ST_MODIFY: begin
            if (!down_skip) begin
               node_cmd.we = 1'b1;
               if (func_ff == FUNC_NODE_DOWN) begin
                  tally_cmd.row_clr = 1'b1;
               end else begin
                  tally_cmd.we = cpu_ok_ff;
               end
            end
         end
         ST_ALLOC: begin
            node_cmd.we     = 1'b1;
            node_cmd.waddr  = free_idx_ff;
            node_cmd.wtotal = COUNT_ONE;
            tally_cmd.we    = cpu_ok_ff;
            tally_cmd.waddr = tally_addr(free_idx_ff, int'(cpu_ff));
            tally_cmd.wdata = COUNT_ONE;
         end
         default: begin
         end
      endcase

      status.busy      = (state_ff != ST_IDLE);
      status.slot_used = slot_used_ff;
   end

   // Datapath next values.
   always_comb begin
      func_in        = func_ff;
      node_in        = node_ff;
      cpu_in         = cpu_ff;
      cpu_ok_in      = cpu_ok_ff;
      iss_in         = iss_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = iss_ff[IDX_BITS-1:0];
      hit_idx_in     = hit_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      total_in       = total_ff;
      sum_in         = sum_ff;
      slot_used_in   = slot_used_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_verdict_in = rsp_verdict_ff;

      // Table walk: one entry read issued per cycle, compared in the next cycle.
      if (issuing) begin
         cmp_vld_in = 1'b1;
         iss_in     = iss_ff + ITER_ONE;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in       = req.func;
               node_in       = (req.func == FUNC_LCPU_DOWN) ? local_node : req.node_num;
               cpu_in        = req.cpu_num;
               cpu_ok_in     = cpu_in_range(req.cpu_num);
               iss_in        = '0;
               free_found_in = 1'b0;
               verdict_in    = VERDICT_GO;
            end
         end
         ST_SEARCH: begin
            if (match) begin
               hit_idx_in = cmp_idx_ff;
               total_in   = rd_entry.total;
            end else if (cmp_vld_ff) begin
               // Remember the lowest free entry for an open that misses.
               if (!slot_used_ff[cmp_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               if (last_cmp) begin
                  verdict_in = ((func_ff == FUNC_OPEN) && !free_avail) ?
                               VERDICT_FULL : VERDICT_GO;
               end
            end
         end
         ST_TALLY_RD: begin
         end
         ST_MODIFY: begin
            iss_in = '0;
            sum_in = '0;
            if (down_skip) begin
               verdict_in = VERDICT_GO;
            end
         end
         ST_ALLOC: begin
            slot_used_in[free_idx_ff] = 1'b1;
            iss_in = '0;
            sum_in = '0;
         end
         ST_SUM: begin
            // Add positive counts; free non-local entries that are not positive.
            if (cmp_vld_ff) begin
               sum_in = sum_next;
               if (!entry_pos && (cmp_idx_ff != '0)) begin
                  slot_used_in[cmp_idx_ff] = 1'b0;
               end
               if (last_cmp) begin
                  verdict_in = cnt_positive(sum_next) ? VERDICT_GO : VERDICT_STOP;
               end
            end
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_used_ff <= {{(NODES-1){1'b0}}, 1'b1};
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_used_ff <= slot_used_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      node_ff        <= node_in;
      cpu_ff         <= cpu_in;
      cpu_ok_ff      <= cpu_ok_in;
      iss_ff         <= iss_in;
      cmp_idx_ff     <= cmp_idx_in;
      hit_idx_ff     <= hit_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      total_ff       <= total_in;
      sum_ff         <= sum_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

endmodule

`default_nettype wire

[rtl/node_cpu_open_count_table_unit.sv]
// Top level of the open count table: local node register, sequencer and the
// two table memories. Depends on oct_pkg, the channel interfaces, oct_seq,
// oct_node_mem and oct_tally_mem.
//
//   Port     Dir   Beat content                                   Accepted when
//   req_ch   in    func, node_num, cpu_num, from_ancestor,         valid && ready
//                  is_link_monitor
//   rsp_ch   out   verdict                                         valid && ready
//   csr_ch   in    local_node                                      valid && ready
//
// One event is handled at a time; ready on req_ch is high only while idle.
// A hit walks the node table twice through one read port (search, then sum
// and free), unless a CPU-down event finds its CPU out of range or its
// counter zero; an ignored event goes straight to the respond state.
// Reset clears all valid bits at once, so no clearing pass is needed.
// A stalled verdict waits in the output register while the next event runs.
`timescale 1ns / 1ps
`default_nettype none

module node_cpu_open_count_table_unit import oct_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   oct_req_if.sink   req_ch,
   oct_rsp_if.source rsp_ch,
   oct_csr_if.sink   csr_ch
);

   node_id_type    local_node_ff, local_node_in;
   node_cmd_type   node_cmd;
   node_entry_type rd_entry;
   tally_cmd_type  tally_cmd;
   count_type      tally_rd;
   seq_status_type status;

   // Local node register; csr_ch is always ready.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      local_node_in = local_node_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         local_node_in = csr_ch.local_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_node_ff <= '0;
      end else begin
         local_node_ff <= local_node_in;
      end
   end

   oct_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .local_node (local_node_ff),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .node_cmd   (node_cmd),
      .rd_entry   (rd_entry),
      .tally_cmd  (tally_cmd),
      .tally_rd   (tally_rd),
      .status     (status)
   );

   oct_node_mem u_node_mem (
      .clock    (clock),
      .reset    (reset),
      .cmd      (node_cmd),
      .rd_entry (rd_entry)
   );

   oct_tally_mem u_tally_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tally_cmd),
      .rd_data (tally_rd)
   );

   // The local entry is never freed.
   a_local_slot_used : assert property (@(posedge clock) disable iff (reset)
      status.slot_used[0])
      else $error("local table entry lost its used bit");

   // One event at a time: no accept in the cycle after an accept.
   a_single_event : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("event accepted while another is in work");

   // A verdict appears only at the end of an event's work.
   a_verdict_from_work : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(status.busy))
      else $error("verdict raised without an event in work");

endmodule

`default_nettype wire
